>>> hw/rtl/olist_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the ordered list unit.
// No dependencies; every other file of the block imports this package.
package olist_pkg;

   localparam int CAPACITY = 128;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int OP_W     = 2;
   localparam int POS_W    = 8;
   localparam int STAT_W   = 2;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;
   localparam logic [OP_W-1:0] OP_FIND   = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd2;
   localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_ROTATE,
      CELL_INSERT,
      CELL_REMOVE
   } cell_mode_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      cell_mode_type            mode;
      logic [IDX_W-1:0]         slot;
      logic signed [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage

>>> hw/rtl/olist_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the ordered list unit.
// Depends on olist_pkg for field widths.
interface olist_req_if import olist_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          operation;
   logic [POS_W-1:0]         position;
   logic signed [DATA_W-1:0] data_value;
   logic [POS_W-1:0]         start_index;

   modport source (output valid, output operation, output position,
                   output data_value, output start_index, input ready);
   modport sink   (input valid, input operation, input position,
                   input data_value, input start_index, output ready);
endinterface

interface olist_rsp_if import olist_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [STAT_W-1:0]        status;
   logic signed [DATA_W-1:0] result_value;
   logic [POS_W-1:0]         found_position;
   logic [POS_W-1:0]         entry_count;
   logic                     is_empty;
   logic                     is_full;

   modport source (output valid, output status, output result_value,
                   output found_position, output entry_count, output is_empty,
                   output is_full, input ready);
   modport sink   (input valid, input status, input result_value,
                   input found_position, input entry_count, input is_empty,
                   input is_full, output ready);
endinterface

>>> hw/rtl/olist_cell.sv
`timescale 1ns / 1ps
// One storage cell of the list chain: holds one entry and takes a value
// from itself, its neighbours or the broadcast command. Depends on olist_pkg.
module olist_cell import olist_pkg::*; (
   input  logic                     clock,
   input  cell_ctrl_type            ctrl,
   input  logic [IDX_W-1:0]         idx,
   input  logic signed [DATA_W-1:0] prev_value,
   input  logic signed [DATA_W-1:0] next_value,
   output logic signed [DATA_W-1:0] value
);

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      case (ctrl.mode)
         CELL_HOLD: begin
            value_in = value_ff;
         end
         CELL_ROTATE: begin
            value_in = next_value;
         end
         CELL_INSERT: begin
            if (idx > ctrl.slot) begin
               value_in = prev_value;
            end else if (idx == ctrl.slot) begin
               value_in = ctrl.value;
            end
         end
         CELL_REMOVE: begin
            if (idx >= ctrl.slot) begin
               value_in = next_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

>>> hw/rtl/ordered_list_insert_remove_search_unit.sv
`timescale 1ns / 1ps
// Top level of the ordered list unit: the chain of cells and its sequencer.
// Depends on olist_pkg, olist_if and olist_cell.

// The list lives in a ring of CAPACITY cells, one entry per cell, with entry
// k of the list in cell k. An insert, and every request rejected by the
// position, full or start checks, is answered in the cycle after it is
// taken: all cells shift up behind the insert slot at once. Read, remove
// and find rotate the whole ring by one cell per cycle through a full turn,
// so that every entry passes the head cell, where it is compared and
// captured; the ring is back in place after the full turn, and the finish
// state then commits the result once the response register is free (a
// remove closes its gap there by a shift down). One request is in work at
// a time; a new word is taken once the sequencer is idle and the response
// register is free or being emptied. The store contents are not cleared by
// reset: only the entry count, the state and the response valid are, and
// entries at or beyond the count are never reported.
module ordered_list_insert_remove_search_unit import olist_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   olist_req_if.sink   req_ch,
   olist_rsp_if.source rsp_ch
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(CAPACITY - 1);

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         step_ff, step_in;
   logic [OP_W-1:0]          op_ff, op_in;
   logic [IDX_W-1:0]         slot_ff, slot_in;
   logic signed [DATA_W-1:0] key_ff, key_in;
   logic [POS_W-1:0]         start_ff, start_in;
   logic                     hit_ff, hit_in;
   logic [POS_W-1:0]         fpos_ff, fpos_in;
   logic signed [DATA_W-1:0] cap_ff, cap_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]        rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [POS_W-1:0]         rsp_fpos_ff, rsp_fpos_in;

   cell_ctrl_type            cell_ctrl;
   logic signed [DATA_W-1:0] cell_value [CAPACITY];
   logic signed [DATA_W-1:0] head_value;

   logic                     rsp_free;
   logic                     accept;
   logic                     pos_in_list;
   logic [CNT_W:0]           count_plus_one;

   // The ring: each cell sees its lower and upper neighbour, wrapping round.
   for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
      olist_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .idx        (IDX_W'(gi)),
         .prev_value (cell_value[(gi + CAPACITY - 1) % CAPACITY]),
         .next_value (cell_value[(gi + 1) % CAPACITY]),
         .value      (cell_value[gi])
      );
   end

   assign head_value = cell_value[0];

   assign rsp_free      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready  = (state_ff == S_IDLE) && rsp_free;
   assign accept        = req_ch.valid && req_ch.ready;

   assign count_plus_one = (CNT_W + 1)'(count_ff) + (CNT_W + 1)'(1);
   assign pos_in_list    = (req_ch.position != '0) && (req_ch.position <= count_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      op_in         = op_ff;
      slot_in       = slot_ff;
      key_in        = key_ff;
      start_in      = start_ff;
      hit_in        = hit_ff;
      fpos_in       = fpos_ff;
      cap_in        = cap_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_fpos_in   = rsp_fpos_ff;

      cell_ctrl.mode  = CELL_HOLD;
      cell_ctrl.slot  = slot_ff;
      cell_ctrl.value = key_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in        = req_ch.operation;
               slot_in      = IDX_W'(req_ch.position - POS_W'(1));
               key_in       = req_ch.data_value;
               start_in     = req_ch.start_index;
               step_in      = '0;
               hit_in       = 1'b0;
               fpos_in      = '0;
               cap_in       = '0;
               rsp_value_in = '0;
               rsp_fpos_in  = '0;
               case (req_ch.operation)
                  OP_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff >= CNT_W'(CAPACITY)) begin
                        rsp_status_in = ST_FULL;
                     end else if ((req_ch.position == '0) ||
                                  ((CNT_W + 1)'(req_ch.position) > count_plus_one)) begin
                        rsp_status_in = ST_BADPOS;
                     end else begin
                        cell_ctrl.mode  = CELL_INSERT;
                        cell_ctrl.slot  = IDX_W'(req_ch.position - POS_W'(1));
                        cell_ctrl.value = req_ch.data_value;
                        count_in        = count_ff + CNT_W'(1);
                        rsp_status_in   = ST_OK;
                     end
                  end
                  OP_REMOVE, OP_READ: begin
                     if (pos_in_list) begin
                        state_in = S_SCAN;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_BADPOS;
                     end
                  end
                  OP_FIND: begin
                     if (req_ch.start_index < count_ff) begin
                        state_in = S_SCAN;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_NOTFOUND;
                     end
                  end
                  default: begin
                     rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
                  end
               endcase
            end
         end

         S_SCAN: begin
            // The head cell holds list entry step_ff during this cycle.
            cell_ctrl.mode = CELL_ROTATE;
            step_in        = step_ff + IDX_W'(1);
            if (step_ff == slot_ff) begin
               cap_in = head_value;
            end
            if ((op_ff == OP_FIND) && !hit_ff && (POS_W'(step_ff) >= start_ff) &&
                (CNT_W'(step_ff) < count_ff) && (head_value == key_ff)) begin
               hit_in  = 1'b1;
               fpos_in = POS_W'(step_ff) + POS_W'(1);
            end
            if (step_ff == LAST_STEP) begin
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            if (rsp_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               case (op_ff)
                  OP_REMOVE: begin
                     cell_ctrl.mode = CELL_REMOVE;
                     count_in       = count_ff - CNT_W'(1);
                     rsp_status_in  = ST_OK;
                     rsp_value_in   = cap_ff;
                  end
                  OP_READ: begin
                     rsp_status_in = ST_OK;
                     rsp_value_in  = cap_ff;
                  end
                  OP_FIND: begin
                     rsp_status_in = hit_ff ? ST_OK : ST_NOTFOUND;
                     rsp_fpos_in   = fpos_ff;
                  end
                  default: begin
                     rsp_status_in = ST_OK;
                  end
               endcase
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff       <= step_in;
      op_ff         <= op_in;
      slot_ff       <= slot_in;
      key_ff        <= key_in;
      start_ff      <= start_in;
      hit_ff        <= hit_in;
      fpos_ff       <= fpos_in;
      cap_ff        <= cap_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_fpos_ff   <= rsp_fpos_in;
   end

   // The count register always reflects the list after the last answered word.
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.result_value   = rsp_value_ff;
   assign rsp_ch.found_position = rsp_fpos_ff;
   assign rsp_ch.entry_count    = POS_W'(count_ff);
   assign rsp_ch.is_empty       = (count_ff == '0);
   assign rsp_ch.is_full        = (count_ff == CNT_W'(CAPACITY));

endmodule

>>> tb/ordered_list_insert_remove_search_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the ordered list unit: directed and random request words,
// each checked against a shadow copy of the list kept by the testbench.
// Depends on olist_pkg, olist_if and the RTL of ordered_list_insert_remove_search_unit.
module ordered_list_insert_remove_search_unit_tb;
   import olist_pkg::*;

   // One request word as the sender offers it.
   typedef struct packed {
      logic [OP_W-1:0]          operation;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] data_value;
      logic [POS_W-1:0]         start_index;
   } olist_request_type;

   // One response word, in the order of the response channel's payload.
   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic signed [DATA_W-1:0] result_value;
      logic [POS_W-1:0]         found_position;
      logic [POS_W-1:0]         entry_count;
      logic                     is_empty;
      logic                     is_full;
   } olist_result_type;

   // Shadow of the list. Every accepted request word is applied to it at
   // once, and the response it must produce is queued; responses leave the
   // block in request order, so each one is checked against the oldest entry.
   class olist_shadow;
      logic signed [DATA_W-1:0] entries [CAPACITY];
      int                       count;
      olist_result_type         awaited_responses [$];
      int                       errors;
      int                       words_taken;
      int                       responses_seen;
      int                       peak_count;
      int                       times_full;
      int                       times_empty;
      int                       ops_taken [4];
      int                       status_seen [4];

      function void note_request(olist_request_type w);
         olist_result_type r;
         int               i;
         int               pos;
         int               first;
         r = '0;
         r.status = ST_OK;
         pos = int'(w.position);
         first = int'(w.start_index);
         words_taken++;
         ops_taken[w.operation]++;
         case (w.operation)
            OP_INSERT: begin
               // A full list refuses the word before the position is looked at.
               if (count >= CAPACITY) begin
                  r.status = ST_FULL;
               end else if (pos == 0 || pos > count + 1) begin
                  r.status = ST_BADPOS;
               end else begin
                  for (i = count; i >= pos; i--)
                     entries[i] = entries[i - 1];
                  entries[pos - 1] = w.data_value;
                  count++;
                  if (count == CAPACITY)
                     times_full++;
               end
            end
            OP_REMOVE: begin
               if (pos == 0 || pos > count) begin
                  r.status = ST_BADPOS;
               end else begin
                  r.result_value = entries[pos - 1];
                  for (i = pos - 1; i + 1 < count; i++)
                     entries[i] = entries[i + 1];
                  count--;
                  if (count == 0)
                     times_empty++;
               end
            end
            OP_READ: begin
               if (pos == 0 || pos > count)
                  r.status = ST_BADPOS;
               else
                  r.result_value = entries[pos - 1];
            end
            default: begin
               // Search from the 0-based start; the position reported is 1-based.
               r.status = ST_NOTFOUND;
               for (i = first; i < count; i++) begin
                  if (entries[i] == w.data_value) begin
                     r.status = ST_OK;
                     r.found_position = POS_W'(i + 1);
                     break;
                  end
               end
            end
         endcase
         r.entry_count = POS_W'(count);
         r.is_empty = (count == 0);
         r.is_full = (count == CAPACITY);
         if (count > peak_count)
            peak_count = count;
         awaited_responses.push_back(r);
      endfunction

      function void compare_field(string name, logic [DATA_W-1:0] want,
                                  logic [DATA_W-1:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
         end
      endfunction

      function void check_response(olist_result_type got);
         olist_result_type want;
         if (awaited_responses.size() == 0) begin
            errors++;
            $display("%0t ns: response word with none outstanding, expected nothing, actual %p",
                     $time, got);
            return;
         end
         want = awaited_responses.pop_front();
         responses_seen++;
         status_seen[got.status]++;
         compare_field("status", DATA_W'(want.status), DATA_W'(got.status));
         compare_field("result_value", want.result_value, got.result_value);
         compare_field("found_position", DATA_W'(want.found_position),
                       DATA_W'(got.found_position));
         compare_field("entry_count", DATA_W'(want.entry_count), DATA_W'(got.entry_count));
         compare_field("is_empty", DATA_W'(want.is_empty), DATA_W'(got.is_empty));
         compare_field("is_full", DATA_W'(want.is_full), DATA_W'(got.is_full));
      endfunction
   endclass

   localparam int HOLD_OFF_CYCLES = 800;
   localparam int HOLD_OFF_AFTER  = 250;
   localparam int RANDOM_WORDS    = 600;

   logic        clock = 1'b0;
   logic        reset;
   olist_shadow shadow = new();
   int          burst_left;
   int          random_words;

   olist_req_if req_ch ();
   olist_rsp_if rsp_ch ();

   ordered_list_insert_remove_search_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Offer one word and hold it until the block takes it. The shadow is
   // updated at the accepting edge. The sender then either carries on with
   // its burst, leaving valid high, or drops valid for a random gap.
   task automatic drive_word(olist_request_type w);
      req_ch.valid       <= 1'b1;
      req_ch.operation   <= w.operation;
      req_ch.position    <= w.position;
      req_ch.data_value  <= w.data_value;
      req_ch.start_index <= w.start_index;
      do @(posedge clock); while (!req_ch.ready);
      shadow.note_request(w);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         // Now and then a long burst, so that stretches with no idling occur.
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(0, 20);
      end
   endtask

   task automatic send(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                       logic signed [DATA_W-1:0] value, logic [POS_W-1:0] start);
      drive_word('{op, pos, value, start});
   endtask

   // Data values favour a small pool, so that find meets duplicates, and the
   // extremes of the signed range.
   function automatic logic signed [DATA_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 4)
         return $signed($urandom_range(0, 7)) - 4;
      if (roll == 4) begin
         case ($urandom_range(0, 4))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return -1;
            3: return 0;
            default: return 100;
         endcase
      end
      return $urandom;
   endfunction

   // Random word with the given percentages of insert, remove and read; the
   // rest are finds. Most positions are legal for the list as it stands,
   // worked out from the shadow, the others probe the range checks.
   function automatic olist_request_type random_word(int pct_insert, int pct_remove,
                                                     int pct_read);
      olist_request_type w;
      int                roll;
      int                n;
      n = shadow.count;
      roll = $urandom_range(0, 99);
      if (roll < pct_insert)
         w.operation = OP_INSERT;
      else if (roll < pct_insert + pct_remove)
         w.operation = OP_REMOVE;
      else if (roll < pct_insert + pct_remove + pct_read)
         w.operation = OP_READ;
      else
         w.operation = OP_FIND;
      w.data_value = pick_value();
      if ($urandom_range(0, 9) == 0) begin
         case ($urandom_range(0, 2))
            0: w.position = '0;
            1: w.position = (w.operation == OP_INSERT) ? POS_W'(n + 2) : POS_W'(n + 1);
            default: w.position = POS_W'($urandom_range(0, 255));
         endcase
      end else if (w.operation == OP_INSERT && n < CAPACITY) begin
         w.position = POS_W'($urandom_range(1, n + 1));
      end else if (n == 0) begin
         w.position = POS_W'($urandom_range(0, 255));
      end else begin
         w.position = POS_W'($urandom_range(1, n));
      end
      if (w.operation == OP_FIND && n > 0 && $urandom_range(0, 1) == 0)
         w.data_value = shadow.entries[$urandom_range(0, n - 1)];
      if ($urandom_range(0, 9) < 7)
         w.start_index = POS_W'($urandom_range(0, n));
      else
         w.start_index = POS_W'($urandom_range(0, CAPACITY));
      return w;
   endfunction

   // Sender: reset, a directed opening, then random phases that sweep the
   // list from empty to full and back.
   initial begin
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.operation   <= OP_INSERT;
      req_ch.position    <= '0;
      req_ch.data_value  <= '0;
      req_ch.start_index <= '0;
      burst_left = 0;
      random_words = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Everything refused on an empty list.
      send(OP_READ, 1, 0, 0);
      send(OP_REMOVE, 0, 0, 0);
      send(OP_FIND, 0, 0, 0);
      send(OP_INSERT, 0, 5, 0);
      send(OP_INSERT, 2, 5, 0);
      // Build [-1, 0, max, min] through inserts at the head, tail and middle.
      send(OP_INSERT, 1, 32'sh7fff_ffff, 0);
      send(OP_INSERT, 2, 32'sh8000_0000, 0);
      send(OP_INSERT, 1, -1, 0);
      send(OP_INSERT, 2, 0, 0);
      send(OP_INSERT, 255, 100, 0);
      send(OP_READ, 1, 0, 0);
      send(OP_READ, 4, 0, 0);
      send(OP_READ, 5, 0, 0);
      send(OP_READ, 255, 0, 0);
      // Finds: a hit at the head, a hit at the last entry, a start past the
      // only match, a start equal to the count and a start at the top.
      send(OP_FIND, 0, -1, 0);
      send(OP_FIND, 0, 32'sh8000_0000, 3);
      send(OP_FIND, 0, -1, 1);
      send(OP_FIND, 0, 0, 4);
      send(OP_FIND, 0, 32'sh7fff_ffff, 128);
      // Removes from the middle, the tail and the head down to empty.
      send(OP_REMOVE, 255, 0, 0);
      send(OP_REMOVE, 2, 0, 0);
      send(OP_REMOVE, 3, 0, 0);
      send(OP_REMOVE, 1, 0, 0);
      send(OP_REMOVE, 1, 0, 0);
      send(OP_INSERT, 1, 100, 0);

      repeat (80) begin
         drive_word(random_word(35, 20, 20));
         random_words++;
      end
      // Fill up, then keep knocking on the full list.
      while (shadow.count < CAPACITY) begin
         drive_word(random_word(85, 5, 5));
         random_words++;
      end
      repeat (10) begin
         drive_word(random_word(85, 5, 5));
         random_words++;
      end
      repeat (80) begin
         drive_word(random_word(30, 30, 20));
         random_words++;
      end
      // Drain to empty and stay there for a while.
      while (shadow.count > 0) begin
         drive_word(random_word(10, 75, 8));
         random_words++;
      end
      repeat (8) begin
         drive_word(random_word(10, 75, 8));
         random_words++;
      end
      while (random_words < RANDOM_WORDS) begin
         drive_word(random_word(35, 20, 20));
         random_words++;
      end
      req_ch.valid <= 1'b0;

      while (shadow.awaited_responses.size() != 0)
         @(posedge clock);
      // A stray word would show up within one full turn of the ring.
      repeat (CAPACITY + 16) @(posedge clock);

      $display("Sent %0d words (%0d insert, %0d remove, %0d read, %0d find), %0d checked.",
               shadow.words_taken, shadow.ops_taken[OP_INSERT], shadow.ops_taken[OP_REMOVE],
               shadow.ops_taken[OP_READ], shadow.ops_taken[OP_FIND], shadow.responses_seen);
      $display("Peak %0d of %0d, full %0d, emptied %0d; ok/full/bad/miss %0d/%0d/%0d/%0d.",
               shadow.peak_count, CAPACITY, shadow.times_full, shadow.times_empty,
               shadow.status_seen[ST_OK], shadow.status_seen[ST_FULL],
               shadow.status_seen[ST_BADPOS], shadow.status_seen[ST_NOTFOUND]);
      if (shadow.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Receiver: its ready steps in turn through four patterns
   // (always ready, one cycle in three, mostly ready, and bursts of stalls).
   // Once enough words have gone in, it holds off for a long stretch so that
   // the response register stays full and the block must refuse new words.
   initial begin : rsp_ready_driver
      int rx_cycle;
      int hold_left;
      int stall_left;
      bit held_off;
      rx_cycle = 0;
      hold_left = 0;
      stall_left = 0;
      held_off = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rx_cycle++;
         if (!held_off && shadow.words_taken >= HOLD_OFF_AFTER) begin
            held_off = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case ((rx_cycle / 512) % 4)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= (rx_cycle % 3 == 0);
               2: rsp_ch.ready <= ($urandom_range(0, 9) < 7);
               default: begin
                  if (stall_left > 0) begin
                     stall_left--;
                     rsp_ch.ready <= 1'b0;
                  end else if ($urandom_range(0, 7) == 0) begin
                     stall_left = $urandom_range(1, 25);
                     rsp_ch.ready <= 1'b0;
                  end else begin
                     rsp_ch.ready <= 1'b1;
                  end
               end
            endcase
         end
      end
   end

   // Response words are taken at the edge where valid and ready are both high.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         shadow.check_response('{rsp_ch.status, rsp_ch.result_value, rsp_ch.found_position,
                                 rsp_ch.entry_count, rsp_ch.is_empty, rsp_ch.is_full});
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #15_000_000;
      $display("%0t ns: watchdog expired with %0d responses outstanding",
               $time, shadow.awaited_responses.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/olist_pkg.sv
hw/rtl/olist_if.sv
hw/rtl/olist_cell.sv
hw/rtl/ordered_list_insert_remove_search_unit.sv
tb/ordered_list_insert_remove_search_unit_tb.sv
